### hdl/strict_priority_job_queue_core_defines.svh
// Assertion macros for the strict priority job queue core.
`ifndef STRICT_PRIORITY_JOB_QUEUE_CORE_DEFINES_SVH
`define STRICT_PRIORITY_JOB_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SPJQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spjq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPJQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spjq assertion failed");

`endif

### hdl/spjq_pkg.sv
// Shared types and constants of the strict priority job queue.
`default_nettype none
package spjq_pkg;

    localparam int CLASS_DEPTH_DEF = 16;
    localparam int CLASS_COUNT_DEF = 3;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int JOB_FIELD_W     = 16;
    localparam int CLASS_FIELD_W   = 2;
    localparam int WAITING_FIELD_W = 6;

    typedef enum logic [1:0] {
        MODE_ADD       = 2'd0,
        MODE_POP_CLASS = 2'd1,
        MODE_POP_TOP   = 2'd2,
        MODE_CLEAR     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                       found;
        logic [CLASS_FIELD_W-1:0]   served_class;
        status_t                    status;
        logic [WAITING_FIELD_W-1:0] jobs_waiting;
    } res_info_t;

endpackage
`default_nettype wire

### hdl/spjq_store.sv
// Handle store: one synchronous RAM holding every class ring.
`default_nettype none
module spjq_store #(
    parameter int DEPTH       = 48,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [HANDLE_BITS-1:0]   wdata,
    output logic      [HANDLE_BITS-1:0]   rdata
);

    logic [HANDLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

### hdl/spjq_ctrl.sv
// Per-class ring pointers, fill counts, class pick and store access.
`default_nettype none
module spjq_ctrl #(
    parameter int CLASS_DEPTH = 16,
    parameter int CLASS_COUNT = 3,
    parameter int HANDLE_BITS = 16,
    localparam int ADDR_W     = $clog2(CLASS_COUNT * CLASS_DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire spjq_pkg::mode_t             mode,
    input  wire logic [1:0]                  queue_class,
    input  wire logic [HANDLE_BITS-1:0]      handle,
    output logic                             mem_we,
    output logic                             mem_re,
    output logic      [ADDR_W-1:0]           mem_addr,
    output logic      [HANDLE_BITS-1:0]      mem_wdata,
    output spjq_pkg::res_info_t              res_info
);
    import spjq_pkg::*;

    localparam int SLOT_W = $clog2(CLASS_DEPTH);
    localparam int FILL_W = $clog2(CLASS_DEPTH + 1);
    localparam int CLS_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int TOT_W  = $clog2(CLASS_COUNT * CLASS_DEPTH + 1);

    logic [SLOT_W-1:0] head_reg [CLASS_COUNT];
    logic [SLOT_W-1:0] head_next[CLASS_COUNT];
    logic [SLOT_W-1:0] tail_reg [CLASS_COUNT];
    logic [SLOT_W-1:0] tail_next[CLASS_COUNT];
    logic [FILL_W-1:0] fill_reg [CLASS_COUNT];
    logic [FILL_W-1:0] fill_next[CLASS_COUNT];
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;

    logic              in_range;
    logic [CLS_W-1:0]  req_idx;
    logic [CLS_W-1:0]  top_idx;
    logic              top_hit;
    logic [CLS_W-1:0]  sel_idx;
    logic              do_add;
    logic              do_pop;
    logic              full_drop;
    logic [SLOT_W-1:0] slot;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(CLASS_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb begin
        in_range = int'(queue_class) < CLASS_COUNT;
        req_idx  = CLS_W'(queue_class);

        // Lowest non-empty class wins.
        top_hit = 1'b0;
        top_idx = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (fill_reg[c] != '0) begin
                top_hit = 1'b1;
                top_idx = CLS_W'(c);
            end
        end

        do_add    = 1'b0;
        do_pop    = 1'b0;
        full_drop = 1'b0;
        sel_idx   = req_idx;
        unique case (mode)
            MODE_ADD: begin
                if (in_range && fill_reg[req_idx] != FILL_W'(CLASS_DEPTH)) begin
                    do_add = 1'b1;
                end else begin
                    full_drop = 1'b1;
                end
            end
            MODE_POP_CLASS: begin
                do_pop = in_range && (fill_reg[req_idx] != '0);
            end
            MODE_POP_TOP: begin
                do_pop  = top_hit;
                sel_idx = top_idx;
            end
            MODE_CLEAR: begin
            end
            default: begin
            end
        endcase

        slot      = do_add ? tail_reg[req_idx] : head_reg[sel_idx];
        mem_we    = accept && do_add;
        mem_re    = accept && do_pop;
        mem_addr  = ADDR_W'(sel_idx) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(slot);
        mem_wdata = handle;

        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (mode == MODE_CLEAR) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                head_next[c] = '0;
                tail_next[c] = '0;
                fill_next[c] = '0;
            end
            total_next = '0;
        end else if (do_add) begin
            tail_next[req_idx] = next_slot(tail_reg[req_idx]);
            fill_next[req_idx] = fill_reg[req_idx] + 1'b1;
            total_next         = total_reg + 1'b1;
        end else if (do_pop) begin
            head_next[sel_idx] = next_slot(head_reg[sel_idx]);
            fill_next[sel_idx] = fill_reg[sel_idx] - 1'b1;
            total_next         = total_reg - 1'b1;
        end

        res_info.found        = do_pop;
        res_info.served_class = do_pop ? CLASS_FIELD_W'(sel_idx) : '0;
        if (full_drop) begin
            res_info.status = STATUS_FULL;
        end else if ((mode == MODE_POP_CLASS || mode == MODE_POP_TOP) && !do_pop) begin
            res_info.status = STATUS_EMPTY;
        end else begin
            res_info.status = STATUS_DONE;
        end
        res_info.jobs_waiting = WAITING_FIELD_W'(total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            total_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

### hdl/strict_priority_job_queue_core.sv
// Top level of the strict priority job queue: stream ports, result stages, checks.
// Keeps CLASS_COUNT FIFO rings of job handles in one synchronous RAM, one ring of
// CLASS_DEPTH entries per class, class 0 served first. Each transaction adds a
// handle, pops from a named class, pops from the lowest-numbered non-empty class,
// or clears all classes, and returns exactly one result. Items are taken one per
// cycle while the output is not blocked: the pointer update happens at acceptance,
// the RAM read returns the next cycle into a pending stage, and an output register
// holds the result until the master side takes it, so a full pipeline of two
// results stalls input only while the output is blocked; a result goes through the
// pending stage, then the output register. No clearing pass is needed after reset.
`default_nettype none
module strict_priority_job_queue_core #(
    parameter int CLASS_DEPTH = spjq_pkg::CLASS_DEPTH_DEF,
    parameter int CLASS_COUNT = spjq_pkg::CLASS_COUNT_DEF,
    parameter int HANDLE_BITS = spjq_pkg::HANDLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] queue_class, [17:2] job_handle, [23:18] zero
    input  wire logic [23:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] job_out, [16] found, [18:17] served_class, [20:19] status,
    // [26:21] jobs_waiting, [31:27] zero
    output logic      [31:0] m_tdata
);
    import spjq_pkg::*;

    localparam int ADDR_W = $clog2(CLASS_COUNT * CLASS_DEPTH);

    logic                   accept;
    logic                   advance;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [HANDLE_BITS-1:0] mem_wdata;
    logic [HANDLE_BITS-1:0] mem_rdata;
    logic [HANDLE_BITS+JOB_FIELD_W-1:0] handle_ext;
    logic [HANDLE_BITS+JOB_FIELD_W-1:0] rdata_ext;
    res_info_t              res_info;

    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    res_info_t              pend_info_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [31:0]            out_data_reg;
    logic [JOB_FIELD_W-1:0] job_out;

    assign advance  = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign handle_ext = {{HANDLE_BITS{1'b0}}, s_tdata[17:2]};
    assign rdata_ext  = {{JOB_FIELD_W{1'b0}}, mem_rdata};
    assign job_out    = pend_info_reg.found ? rdata_ext[JOB_FIELD_W-1:0] : '0;

    spjq_ctrl #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .CLASS_COUNT (CLASS_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .mode        (mode_t'(s_tuser)),
        .queue_class (s_tdata[1:0]),
        .handle      (handle_ext[HANDLE_BITS-1:0]),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .res_info    (res_info)
    );

    spjq_store #(
        .DEPTH       (CLASS_COUNT * CLASS_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        pend_valid_next = accept || (pend_valid_reg && !advance);
        out_valid_next  = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payloads while stalled; RAM data stays put until the next read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_info_reg <= res_info;
        end
        if (advance) begin
            out_data_reg <= {5'b0, pend_info_reg.jobs_waiting, pend_info_reg.status,
                             pend_info_reg.served_class, pend_info_reg.found, job_out};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "strict_priority_job_queue_core_defines.svh"

    `SPJQ_ASSERT_NOW(a_found_done, aclk, aresetn, m_tvalid && m_tdata[16], m_tdata[20:19] == STATUS_DONE)
    `SPJQ_ASSERT_NOW(a_empty_no_job, aclk, aresetn, m_tvalid && m_tdata[20:19] == STATUS_EMPTY, !m_tdata[16] && m_tdata[15:0] == '0)
    `SPJQ_ASSERT_NEXT(a_accept_pends, aclk, aresetn, accept, pend_valid_reg)

endmodule
`default_nettype wire
